>>> rtl/zlmc_pkg.sv
// Shared types, codes and reset constants for the zone lighting mode controller.
package zlmc_pkg;

   localparam int ZONES_DEFAULT = 8;

   // Configuration register reset values
   localparam logic [6:0]  DAYLIGHT_OFF_RESET = 7'd70;
   localparam logic [6:0]  TRAFFIC_RESET      = 7'd60;
   localparam logic [31:0] MOTION_HOLD_RESET  = 32'd10000;
   localparam logic [6:0]  ECO_RESET          = 7'd20;
   localparam logic [6:0]  PREDICTIVE_RESET   = 7'd50;
   localparam logic [6:0]  FAILSAFE_RESET     = 7'd70;
   localparam logic [6:0]  FULL_RESET         = 7'd100;

   typedef enum logic [2:0] {
      CSR_DAYLIGHT_OFF = 3'd0,
      CSR_TRAFFIC      = 3'd1,
      CSR_MOTION_HOLD  = 3'd2,
      CSR_ECO          = 3'd3,
      CSR_PREDICTIVE   = 3'd4,
      CSR_FAILSAFE     = 3'd5,
      CSR_FULL         = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_SENSOR  = 3'd0,
      OP_PREDICT = 3'd1,
      OP_MANUAL  = 3'd2,
      OP_AUTO    = 3'd3,
      OP_TICK    = 3'd4
   } opcode_type;

   typedef enum logic [2:0] {
      MODE_DAY_OFF    = 3'd0,
      MODE_ECO        = 3'd1,
      MODE_PREDICTIVE = 3'd2,
      MODE_OCCUPIED   = 3'd3,
      MODE_MANUAL     = 3'd4,
      MODE_FAILSAFE   = 3'd5,
      MODE_EMERGENCY  = 3'd6
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_WALK  = 2'd1,
      ST_DRAIN = 2'd2
   } ctrl_state_type;

   typedef struct packed {
      logic evt_write;   // accepted request is a zone event
      logic tick_load;   // accepted request is an update tick
      logic rd_en;       // read zone record at rd_zone
      logic rd_last;     // this read is the final zone
   } ctrl_cmd_type;

   typedef struct packed {
      logic pipe_busy;   // reads or results still in flight
   } ctrl_status_type;

endpackage

>>> rtl/zlmc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module zlmc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/zlmc_ctrl.sv
// Controller: request acceptance and the zone walk sequencer.
module zlmc_ctrl #(
   parameter int ZONES = zlmc_pkg::ZONES_DEFAULT,
   parameter int ZIW   = (ZONES > 1) ? $clog2(ZONES) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [2:0]                req_opcode,
   output logic                      busy,
   output zlmc_pkg::ctrl_cmd_type    cmd,
   output logic [ZIW-1:0]            rd_zone,
   input  zlmc_pkg::ctrl_status_type status
);

   localparam logic [ZIW-1:0] LAST_ZONE = ZIW'(ZONES - 1);

   zlmc_pkg::ctrl_state_type state_ff, state_in;
   logic [ZIW-1:0]           cnt_ff, cnt_in;
   logic                     accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= zlmc_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      accept        = 1'b0;
      cmd.evt_write = 1'b0;
      cmd.tick_load = 1'b0;
      cmd.rd_en     = 1'b0;
      cmd.rd_last   = 1'b0;
      case (state_ff)
         zlmc_pkg::ST_IDLE: begin
            accept = start;
            if (accept && req_opcode == zlmc_pkg::OP_TICK) begin
               cmd.tick_load = 1'b1;
               cnt_in        = '0;
               state_in      = zlmc_pkg::ST_WALK;
            end else if (accept) begin
               cmd.evt_write = 1'b1;
            end
         end
         zlmc_pkg::ST_WALK: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_last = (cnt_ff == LAST_ZONE);
            if (cmd.rd_last) begin
               state_in = zlmc_pkg::ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         zlmc_pkg::ST_DRAIN: begin
            // hold until the last result has left
            if (!status.pipe_busy) begin
               state_in = zlmc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = zlmc_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy    = (state_ff != zlmc_pkg::ST_IDLE);
   assign rd_zone = cnt_ff;

endmodule

>>> rtl/zlmc_datapath.sv
// Datapath: configuration registers, zone record RAMs and the mode decision.
module zlmc_datapath #(
   parameter int ZONES = zlmc_pkg::ZONES_DEFAULT,
   parameter int ZIW   = (ZONES > 1) ? $clog2(ZONES) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  logic [2:0]                csr_index,
   input  logic [31:0]               csr_data,
   input  zlmc_pkg::ctrl_cmd_type    cmd,
   input  logic [ZIW-1:0]            rd_zone,
   output zlmc_pkg::ctrl_status_type status,
   input  logic [2:0]                req_opcode,
   input  logic [7:0]                req_zone_index,
   input  logic signed [31:0]        req_percent_value,
   input  logic                      req_motion_seen,
   input  logic                      req_sensor_ok,
   input  logic [63:0]               req_time_ms,
   input  logic                      req_emergency,
   output logic                      rsp_strobe,
   output logic [5:0]                rsp_out_zone,
   output logic [2:0]                rsp_out_mode,
   output logic [6:0]                rsp_out_brightness,
   output logic                      rsp_out_last
);

   function automatic logic [6:0] pct_clamp(input logic signed [31:0] v);
      logic [6:0] r;
      if (v[31]) begin
         r = 7'd0;
      end else if (v > 32'sd100) begin
         r = 7'd100;
      end else begin
         r = v[6:0];
      end
      return r;
   endfunction

   // configuration
   logic [6:0]  daylight_off_ff, traffic_ff, eco_ff, predictive_ff, failsafe_ff, full_ff;
   logic [31:0] motion_hold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         daylight_off_ff <= zlmc_pkg::DAYLIGHT_OFF_RESET;
         traffic_ff      <= zlmc_pkg::TRAFFIC_RESET;
         motion_hold_ff  <= zlmc_pkg::MOTION_HOLD_RESET;
         eco_ff          <= zlmc_pkg::ECO_RESET;
         predictive_ff   <= zlmc_pkg::PREDICTIVE_RESET;
         failsafe_ff     <= zlmc_pkg::FAILSAFE_RESET;
         full_ff         <= zlmc_pkg::FULL_RESET;
      end else if (csr_write) begin
         case (csr_index)
            zlmc_pkg::CSR_DAYLIGHT_OFF: daylight_off_ff <= csr_data[6:0];
            zlmc_pkg::CSR_TRAFFIC:      traffic_ff      <= csr_data[6:0];
            zlmc_pkg::CSR_MOTION_HOLD:  motion_hold_ff  <= csr_data;
            zlmc_pkg::CSR_ECO:          eco_ff          <= csr_data[6:0];
            zlmc_pkg::CSR_PREDICTIVE:   predictive_ff   <= csr_data[6:0];
            zlmc_pkg::CSR_FAILSAFE:     failsafe_ff     <= csr_data[6:0];
            zlmc_pkg::CSR_FULL:         full_ff         <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   // event decode
   logic           zone_ok;
   logic [ZIW-1:0] wr_zone;
   logic           wr_sens, wr_time, wr_demand, wr_manual;
   logic [6:0]     pct;

   assign zone_ok   = ({1'b0, req_zone_index} < 9'(ZONES));
   assign wr_zone   = req_zone_index[ZIW-1:0];
   assign pct       = pct_clamp(req_percent_value);
   assign wr_sens   = cmd.evt_write && zone_ok && req_opcode == zlmc_pkg::OP_SENSOR;
   assign wr_time   = wr_sens && req_motion_seen;
   assign wr_demand = cmd.evt_write && zone_ok && req_opcode == zlmc_pkg::OP_PREDICT;
   assign wr_manual = cmd.evt_write && zone_ok &&
                      (req_opcode == zlmc_pkg::OP_MANUAL || req_opcode == zlmc_pkg::OP_AUTO);

   // zone records: sens = {daylight, motion, healthy}, manual = {override, level}
   logic [8:0]  sens_q;
   logic [63:0] time_q;
   logic [6:0]  demand_q;
   logic [7:0]  manual_q;
   logic [7:0]  manual_wdata;

   assign manual_wdata = (req_opcode == zlmc_pkg::OP_MANUAL) ? {1'b1, pct} : 8'd0;

   zlmc_ram #(.WIDTH(9), .DEPTH(ZONES)) u_sens_ram (
      .clock   (clock),
      .wr_en   (wr_sens),
      .wr_addr (wr_zone),
      .wr_data ({pct, req_motion_seen, req_sensor_ok}),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_zone),
      .rd_data (sens_q)
   );

   zlmc_ram #(.WIDTH(64), .DEPTH(ZONES)) u_time_ram (
      .clock   (clock),
      .wr_en   (wr_time),
      .wr_addr (wr_zone),
      .wr_data (req_time_ms),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_zone),
      .rd_data (time_q)
   );

   zlmc_ram #(.WIDTH(7), .DEPTH(ZONES)) u_demand_ram (
      .clock   (clock),
      .wr_en   (wr_demand),
      .wr_addr (wr_zone),
      .wr_data (pct),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_zone),
      .rd_data (demand_q)
   );

   zlmc_ram #(.WIDTH(8), .DEPTH(ZONES)) u_manual_ram (
      .clock   (clock),
      .wr_en   (wr_manual),
      .wr_addr (wr_zone),
      .wr_data (manual_wdata),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_zone),
      .rd_data (manual_q)
   );

   // written-once marks; an unwritten record reads as all zero
   logic [ZONES-1:0] sens_vld_ff, time_vld_ff, demand_vld_ff, manual_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sens_vld_ff   <= '0;
         time_vld_ff   <= '0;
         demand_vld_ff <= '0;
         manual_vld_ff <= '0;
      end else begin
         if (wr_sens)   sens_vld_ff[wr_zone]   <= 1'b1;
         if (wr_time)   time_vld_ff[wr_zone]   <= 1'b1;
         if (wr_demand) demand_vld_ff[wr_zone] <= 1'b1;
         if (wr_manual) manual_vld_ff[wr_zone] <= 1'b1;
      end
   end

   // tick operands
   logic [63:0] now_ff;
   logic        emg_ff;

   always_ff @(posedge clock) begin
      if (cmd.tick_load) begin
         now_ff <= req_time_ms;
         emg_ff <= req_emergency;
      end
   end

   // read stage, aligned with RAM output
   logic           s1_valid_ff;
   logic [ZIW-1:0] s1_zone_ff;
   logic           s1_last_ff;
   logic           s1_sens_vld_ff, s1_time_vld_ff, s1_demand_vld_ff, s1_manual_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         s1_zone_ff       <= rd_zone;
         s1_last_ff       <= cmd.rd_last;
         s1_sens_vld_ff   <= sens_vld_ff[rd_zone];
         s1_time_vld_ff   <= time_vld_ff[rd_zone];
         s1_demand_vld_ff <= demand_vld_ff[rd_zone];
         s1_manual_vld_ff <= manual_vld_ff[rd_zone];
      end
   end

   // decision
   logic [6:0]  daylight, demand, manual_lvl;
   logic        motion, healthy, override_on, occupied;
   logic [64:0] diff;
   zlmc_pkg::mode_type mode_in;
   logic [6:0]  bright_in;

   assign daylight    = s1_sens_vld_ff ? sens_q[8:2] : 7'd0;
   assign motion      = s1_sens_vld_ff & sens_q[1];
   assign healthy     = s1_sens_vld_ff & sens_q[0];
   assign demand      = s1_demand_vld_ff ? demand_q : 7'd0;
   assign override_on = s1_manual_vld_ff & manual_q[7];
   assign manual_lvl  = manual_q[6:0];

   // borrow out of diff means time went back
   assign diff     = {1'b0, now_ff} - {1'b0, time_q};
   assign occupied = motion ||
                     (s1_time_vld_ff && !diff[64] && diff[63:32] == 32'd0 &&
                      diff[31:0] <= motion_hold_ff);

   always_comb begin
      if (emg_ff) begin
         mode_in = zlmc_pkg::MODE_EMERGENCY;  bright_in = full_ff;
      end else if (!healthy) begin
         mode_in = zlmc_pkg::MODE_FAILSAFE;   bright_in = failsafe_ff;
      end else if (override_on) begin
         mode_in = zlmc_pkg::MODE_MANUAL;     bright_in = manual_lvl;
      end else if (daylight >= daylight_off_ff) begin
         mode_in = zlmc_pkg::MODE_DAY_OFF;    bright_in = 7'd0;
      end else if (occupied) begin
         mode_in = zlmc_pkg::MODE_OCCUPIED;   bright_in = full_ff;
      end else if (demand >= traffic_ff) begin
         mode_in = zlmc_pkg::MODE_PREDICTIVE; bright_in = predictive_ff;
      end else begin
         mode_in = zlmc_pkg::MODE_ECO;        bright_in = eco_ff;
      end
   end

   // result register
   logic               rsp_valid_ff;
   logic [ZIW-1:0]     rsp_zone_ff;
   zlmc_pkg::mode_type rsp_mode_ff;
   logic [6:0]         rsp_bright_ff;
   logic               rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         rsp_zone_ff   <= s1_zone_ff;
         rsp_mode_ff   <= mode_in;
         rsp_bright_ff <= bright_in;
         rsp_last_ff   <= s1_last_ff;
      end
   end

   assign rsp_strobe         = rsp_valid_ff;
   assign rsp_out_zone       = 6'(rsp_zone_ff);
   assign rsp_out_mode       = rsp_mode_ff;
   assign rsp_out_brightness = rsp_bright_ff;
   assign rsp_out_last       = rsp_last_ff & rsp_valid_ff;

   assign status.pipe_busy = s1_valid_ff | rsp_valid_ff;

endmodule

>>> rtl/zone_lighting_mode_controller_core.sv
// Top level of the zone lighting mode controller.
//
//   channel   handshake              payload
//   req_      start / busy           opcode, zone, percent, flags, time, emergency
//   rsp_      rsp_strobe (1 cycle)   zone, mode, brightness, last
//   csr_      csr_valid / csr_ready  csr_index, csr_data
//
// A zone event is written at the accepting edge and busy stays low. During an
// update tick busy stays high while the walk reads one zone record a cycle from
// the record RAMs; each result passes the RAM read register and the result
// register, one per cycle in zone order. Results cannot be stalled. Reset is
// synchronous and leaves all zones unwritten (failsafe on a tick unless emergency).
module zone_lighting_mode_controller_core #(
   parameter int ZONES = zlmc_pkg::ZONES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_opcode,
   input  logic [7:0]         req_zone_index,
   input  logic signed [31:0] req_percent_value,
   input  logic               req_motion_seen,
   input  logic               req_sensor_ok,
   input  logic [63:0]        req_time_ms,
   input  logic               req_emergency,
   output logic               rsp_strobe,
   output logic [5:0]         rsp_out_zone,
   output logic [2:0]         rsp_out_mode,
   output logic [6:0]         rsp_out_brightness,
   output logic               rsp_out_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   localparam int ZIW = (ZONES > 1) ? $clog2(ZONES) : 1;

   zlmc_pkg::ctrl_cmd_type    cmd;
   zlmc_pkg::ctrl_status_type status;
   logic [ZIW-1:0]            rd_zone;

   assign csr_ready = 1'b1;

   zlmc_ctrl #(.ZONES(ZONES), .ZIW(ZIW)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .busy       (busy),
      .cmd        (cmd),
      .rd_zone    (rd_zone),
      .status     (status)
   );

   zlmc_datapath #(.ZONES(ZONES), .ZIW(ZIW)) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write          (csr_valid & csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .cmd                (cmd),
      .rd_zone            (rd_zone),
      .status             (status),
      .req_opcode         (req_opcode),
      .req_zone_index     (req_zone_index),
      .req_percent_value  (req_percent_value),
      .req_motion_seen    (req_motion_seen),
      .req_sensor_ok      (req_sensor_ok),
      .req_time_ms        (req_time_ms),
      .req_emergency      (req_emergency),
      .rsp_strobe         (rsp_strobe),
      .rsp_out_zone       (rsp_out_zone),
      .rsp_out_mode       (rsp_out_mode),
      .rsp_out_brightness (rsp_out_brightness),
      .rsp_out_last       (rsp_out_last)
   );

   a_rsp_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result outside busy window");

   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_opcode == zlmc_pkg::OP_TICK |=> busy)
      else $error("update tick did not raise busy");

   a_zone_order: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_out_last |=>
         rsp_strobe && rsp_out_zone == 6'($past(rsp_out_zone) + 6'd1))
      else $error("zone results out of order or gapped");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_out_last |=> !rsp_strobe)
      else $error("result after final zone");

endmodule
